>>> hw/rtl/fac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fac_pkg
// Shared types, constants and table builders of the feedforward compressor.
// ----------------------------------------------------------------------------
package fac_pkg;

  localparam int SampleBitsDef    = 16;
  localparam int TableAddrBitsDef = 8;

  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 16;

  // register indexes of the configuration port
  localparam logic [CfgIdxBits-1:0] REG_ENABLE    = 3'd0;
  localparam logic [CfgIdxBits-1:0] REG_THRESHOLD = 3'd1;
  localparam logic [CfgIdxBits-1:0] REG_SLOPE     = 3'd2;
  localparam logic [CfgIdxBits-1:0] REG_LEVEL     = 3'd3;
  localparam logic [CfgIdxBits-1:0] REG_ATTACK    = 3'd4;
  localparam logic [CfgIdxBits-1:0] REG_RELEASE   = 3'd5;

  localparam logic signed [15:0] ThresholdRst = -16'sd5120;
  localparam logic signed [15:0] SlopeRst     = -16'sd192;
  localparam logic [15:0]        LevelRst     = 16'd65000;
  localparam logic [15:0]        AttackRst    = 16'd65300;
  localparam logic [15:0]        ReleaseRst   = 16'd65500;

  // 10*log10(2) in Q2.16 and log2(10)/20 in Q0.16
  localparam logic [17:0] LogK = 18'd197283;
  localparam logic [13:0] ExpK = 14'd10885;

  typedef struct packed {
    logic                   enable;
    logic signed [15:0]     threshold_db;
    logic signed [15:0]     slope;
    logic [15:0]            level_coeff;
    logic [15:0]            attack_coeff;
    logic [15:0]            release_coeff;
  } cfg_t;

  // datapath work steps
  typedef enum logic [3:0] {
    STP_IDLE, STP_SQ, STP_PA, STP_PB, STP_PS, STP_LG, STP_LV, STP_DF,
    STP_TG, STP_GA, STP_GB, STP_GS, STP_EX, STP_GN, STP_AP, STP_OUT
  } step_t;

  typedef struct packed {
    logic  load;    // take a new request sample
    step_t step;
    logic  bypass;  // pass the sample through
    logic  fin;     // write the result register
  } cmd_t;

  // integer square root, fixed iteration count
  function automatic longint unsigned isqrt64(input longint unsigned v);
    longint unsigned res;
    longint unsigned bit_r;
    longint unsigned rem;
    res   = 0;
    bit_r = 64'd1 << 62;
    rem   = v;
    for (int j = 0; j < 32; j++) begin
      if (bit_r > rem) bit_r = bit_r >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (bit_r != 0) begin
        if (rem >= res + bit_r) begin
          rem = rem - (res + bit_r);
          res = (res >> 1) + bit_r;
        end else begin
          res = res >> 1;
        end
        bit_r = bit_r >> 2;
      end
    end
    return res;
  endfunction

  // log2(1 + idx/2^abits) in Q0.16
  function automatic logic [15:0] log2_rom(input int idx, input int abits);
    longint unsigned x;
    logic [15:0]     r;
    x = (longint'(64'd1 << abits) + longint'(idx)) << (30 - abits);
    r = '0;
    for (int b = 0; b < 16; b++) begin
      x = (x * x) >> 30;
      r = r << 1;
      if (x >= (64'd1 << 31)) begin
        r[0] = 1'b1;
        x = x >> 1;
      end
    end
    return r;
  endfunction

  // 2^(idx/2^abits) in Q1.30
  function automatic logic [31:0] exp2_rom(input int idx, input int abits);
    longint unsigned root;
    longint unsigned t;
    root = 64'd1 << 31;
    t    = 64'd1 << 30;
    for (int k = 1; k <= abits; k++) begin
      root = isqrt64(root << 30);
      if (((idx >> (abits - k)) & 1) != 0) t = (t * root + (64'd1 << 29)) >> 30;
    end
    return t[31:0];
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/fac_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fac_in_if / fac_out_if
// Valid/ready sample channels of the compressor.
// ----------------------------------------------------------------------------
interface fac_in_if
  import fac_pkg::*;
#(
  parameter int SAMPLE_BITS = SampleBitsDef
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface fac_out_if
  import fac_pkg::*;
#(
  parameter int SAMPLE_BITS = SampleBitsDef
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/fac_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fac_ctrl
// Sequencer: walks the datapath through the steps of one sample.
// ----------------------------------------------------------------------------
module fac_ctrl
  import fac_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  enable,
  input  wire  in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire  out_ready,
  output cmd_t cmd
);

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001, S_SQ = 16'h0002, S_PA = 16'h0004, S_PB = 16'h0008,
    S_PS   = 16'h0010, S_LG = 16'h0020, S_LV = 16'h0040, S_DF = 16'h0080,
    S_TG   = 16'h0100, S_GA = 16'h0200, S_GB = 16'h0400, S_GS = 16'h0800,
    S_EX   = 16'h1000, S_GN = 16'h2000, S_AP = 16'h4000, S_OUT = 16'h8000
  } state_t;

  state_t state_r, state_nxt;
  logic   byp_r, byp_nxt;
  logic   ovld_r, ovld_nxt;
  logic   accept, slot_free;
  step_t  step;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !ovld_r || out_ready;
  assign out_valid = ovld_r;

  // advance through the steps
  always_comb begin
    state_nxt = state_r;
    byp_nxt   = byp_r;
    step      = STP_IDLE;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          byp_nxt   = !enable;
          state_nxt = enable ? S_SQ : S_OUT;
        end
      end
      S_SQ:  begin step = STP_SQ; state_nxt = S_PA; end
      S_PA:  begin step = STP_PA; state_nxt = S_PB; end
      S_PB:  begin step = STP_PB; state_nxt = S_PS; end
      S_PS:  begin step = STP_PS; state_nxt = S_LG; end
      S_LG:  begin step = STP_LG; state_nxt = S_LV; end
      S_LV:  begin step = STP_LV; state_nxt = S_DF; end
      S_DF:  begin step = STP_DF; state_nxt = S_TG; end
      S_TG:  begin step = STP_TG; state_nxt = S_GA; end
      S_GA:  begin step = STP_GA; state_nxt = S_GB; end
      S_GB:  begin step = STP_GB; state_nxt = S_GS; end
      S_GS:  begin step = STP_GS; state_nxt = S_EX; end
      S_EX:  begin step = STP_EX; state_nxt = S_GN; end
      S_GN:  begin step = STP_GN; state_nxt = S_AP; end
      S_AP:  begin step = STP_AP; state_nxt = S_OUT; end
      S_OUT: begin
        step = STP_OUT;
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // hold the result valid until taken
  always_comb begin
    ovld_nxt = ovld_r;
    if (out_ready) ovld_nxt = 1'b0;
    if (state_r == S_OUT && slot_free) ovld_nxt = 1'b1;
  end

  assign cmd.load   = accept;
  assign cmd.step   = step;
  assign cmd.bypass = byp_r;
  assign cmd.fin    = (state_r == S_OUT) && slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      byp_r   <= 1'b0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      byp_r   <= byp_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/fac_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fac_dp
// Datapath: one shared multiplier, detector and gain state, log/exp tables.
// ----------------------------------------------------------------------------
module fac_dp
  import fac_pkg::*;
#(
  parameter int SAMPLE_BITS     = SampleBitsDef,
  parameter int TABLE_ADDR_BITS = TableAddrBitsDef
)(
  input  wire                           clk,
  input  wire                           rst_n,
  input  cfg_t                          cfg,
  input  cmd_t                          cmd,
  input  wire  signed [SAMPLE_BITS-1:0] sample_in,
  output logic signed [SAMPLE_BITS-1:0] sample_out
);

  localparam int A     = TABLE_ADDR_BITS;
  localparam int Depth = 1 << A;
  localparam int D     = 2 * (SAMPLE_BITS - 1) - 30;
  localparam int Dr    = (D > 0) ? D : 0;
  localparam int Dl    = (D < 0) ? -D : 0;

  logic [15:0] log_tbl [Depth];
  logic [31:0] exp_tbl [Depth];

  // constant tables
  for (genvar i = 0; i < Depth; i++) begin : g_tbl
    assign log_tbl[i] = log2_rom(i, A);
    assign exp_tbl[i] = exp2_rom(i, A);
  end

  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [SAMPLE_BITS-1:0] y_r;
  logic signed [65:0]            prod_r, acc_r;
  logic [30:0]                   sq_r;
  logic [31:0]                   pow_r;
  logic signed [17:0]            diff_r;
  logic signed [16:0]            tgt_r;
  logic [15:0]                   k_r;
  logic signed [16:0]            gdb_r;
  logic [30:0]                   gain_r;

  logic signed [32:0] op_a, op_b;
  logic signed [65:0] mul;
  logic [20:0]        neg;

  // shared multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (cmd.step)
      STP_SQ: begin op_a = 33'(x_r); op_b = 33'(x_r); end
      STP_PA: begin op_a = $signed({17'd0, cfg.level_coeff}); op_b = $signed({1'b0, pow_r}); end
      STP_PB: begin
        op_a = $signed(33'd65536 - {17'd0, cfg.level_coeff});
        op_b = $signed({2'b0, sq_r});
      end
      STP_LG: begin op_a = $signed({12'd0, neg}); op_b = $signed({15'd0, LogK}); end
      STP_DF: begin op_a = 33'(diff_r); op_b = 33'(cfg.slope); end
      STP_GA: begin op_a = $signed({17'd0, k_r}); op_b = 33'(gdb_r); end
      STP_GB: begin op_a = $signed(33'd65536 - {17'd0, k_r}); op_b = 33'(tgt_r); end
      STP_EX: begin op_a = 33'(-gdb_r); op_b = $signed({19'd0, ExpK}); end
      STP_AP: begin op_a = 33'(x_r); op_b = $signed({2'b0, gain_r}); end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign mul = op_a * op_b;

  // power smoothing sum and floor
  logic [30:0]        sq;
  logic signed [65:0] sum_p;
  logic [31:0]        p_raw, p_fl;
  logic [63:0]        sq_full;
  assign sq_full = 64'(prod_r);
  assign sq      = 31'((sq_full >> Dr) << Dl);
  assign sum_p   = acc_r + prod_r + 66'sd32768;
  assign p_raw   = sum_p[47:16];
  assign p_fl    = (p_raw == 32'd0) ? 32'd1 : p_raw;

  // leading one and table index of the power
  logic [4:0]   e;
  logic [63:0]  shv;
  logic [A-1:0] lidx;
  logic [21:0]  lg;
  always_comb begin
    e = '0;
    for (int i = 0; i < 32; i++) begin
      if (pow_r[i]) e = 5'(i);
    end
  end
  assign shv  = ({32'd0, pow_r} << A) >> e;
  assign lidx = shv[A-1:0];
  assign lg   = {1'b0, e, 16'd0} + {6'd0, log_tbl[lidx]};
  assign neg  = (lg > 22'(30 << 16)) ? 21'd0 : 21'(22'(30 << 16) - lg);

  // level and its distance to the threshold
  logic [15:0]        lmag;
  logic signed [65:0] lsum;
  logic signed [17:0] diff;
  assign lsum = prod_r + 66'sd8388608;
  assign lmag = lsum[39:24];
  assign diff = -$signed({2'b0, lmag}) - 18'(cfg.threshold_db);

  // target gain, limited to [-32768, 0]
  logic signed [65:0] tsum;
  logic signed [16:0] tgt;
  assign tsum = (prod_r + 66'sd128) >>> 8;
  always_comb begin
    priority if (tsum > 66'sd0)      tgt = 17'sd0;
    else if (tsum < -66'sd32768)     tgt = -17'sd32768;
    else                             tgt = 17'(tsum);
  end

  // smoothed gain, limited to [-32768, 0]
  logic signed [65:0] gsum;
  logic signed [16:0] g;
  assign gsum = (acc_r + prod_r + 66'sd32768) >>> 16;
  always_comb begin
    priority if (gsum > 66'sd0)      g = 17'sd0;
    else if (gsum < -66'sd32768)     g = -17'sd32768;
    else                             g = 17'(gsum);
  end

  // exponent split and linear gain
  logic [20:0]  n;
  logic [15:0]  nfrac;
  logic [5:0]   ip;
  logic [15:0]  frac;
  logic [A-1:0] eidx;
  logic [31:0]  gain;
  assign n     = prod_r[28:8] + 21'(prod_r[7]);
  assign nfrac = n[15:0];
  assign ip    = {1'b0, n[20:16]} + 6'(nfrac != 16'd0);
  assign frac  = (nfrac == 16'd0) ? 16'd0 : 16'(17'h10000 - {1'b0, nfrac});
  assign eidx  = frac[15:16-A];
  assign gain  = exp_tbl[eidx] >> ip;

  // output rounding and saturation
  localparam logic signed [65:0] SMax = 66'sd1 <<< (SAMPLE_BITS - 1);
  logic signed [65:0]            ysum;
  logic signed [SAMPLE_BITS-1:0] y;
  assign ysum = (prod_r + 66'sd536870912) >>> 30;
  always_comb begin
    priority if (ysum > SMax - 66'sd1) y = SAMPLE_BITS'(SMax - 66'sd1);
    else if (ysum < -SMax)             y = SAMPLE_BITS'(-SMax);
    else                               y = SAMPLE_BITS'(ysum);
  end

  // detector and gain state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pow_r <= 32'd1;
      gdb_r <= '0;
    end else begin
      if (cmd.step == STP_PS) pow_r <= p_fl;
      if (cmd.step == STP_GS) gdb_r <= g;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) x_r <= sample_in;
    unique case (cmd.step)
      STP_SQ, STP_LG, STP_DF, STP_GA, STP_EX, STP_AP: prod_r <= mul;
      STP_PA: begin sq_r <= sq; prod_r <= mul; end
      STP_PB, STP_GB: begin acc_r <= prod_r; prod_r <= mul; end
      STP_LV: diff_r <= diff;
      STP_TG: begin
        tgt_r <= tgt;
        k_r   <= (tgt < gdb_r) ? cfg.attack_coeff : cfg.release_coeff;
      end
      STP_GN: gain_r <= gain[30:0];
      default: ;
    endcase
    if (cmd.fin) y_r <= cmd.bypass ? x_r : y;
  end

  assign sample_out = y_r;

endmodule
`default_nettype wire

>>> hw/rtl/feedforward_audio_compressor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// feedforward_audio_compressor
// RMS-detecting feedforward compressor: config registers, sequencer, datapath.
// ----------------------------------------------------------------------------
// When enabled, an accepted request walks the 14 datapath steps in order, then
//   the output state; when disabled it goes straight there (pass-through).
// A stalled output holds the output state. No new request is taken until the
//   previous sample has left it; the multiplying steps share one multiplier.
// A new request is taken while the previous result waits in the output register.
// Reset (synchronous, rst_n low): registers to defaults, power to one LSB,
//   gain to 0 dB, no result pending.
module feedforward_audio_compressor
  import fac_pkg::*;
#(
  parameter int SAMPLE_BITS     = SampleBitsDef,
  parameter int TABLE_ADDR_BITS = TableAddrBitsDef
)(
  input  wire                   clk,
  input  wire                   rst_n,
  fac_in_if.sink                in_chan,
  fac_out_if.source             out_chan,
  input  wire                   cfg_we,
  input  wire  [CfgIdxBits-1:0] cfg_idx,
  input  wire  [CfgDataBits-1:0] cfg_wdata
);

  cfg_t cfg_r;
  cmd_t cmd;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable        <= 1'b0;
      cfg_r.threshold_db  <= ThresholdRst;
      cfg_r.slope         <= SlopeRst;
      cfg_r.level_coeff   <= LevelRst;
      cfg_r.attack_coeff  <= AttackRst;
      cfg_r.release_coeff <= ReleaseRst;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ENABLE:    cfg_r.enable        <= cfg_wdata[0];
        REG_THRESHOLD: cfg_r.threshold_db  <= $signed(cfg_wdata);
        REG_SLOPE:     cfg_r.slope         <= $signed(cfg_wdata);
        REG_LEVEL:     cfg_r.level_coeff   <= cfg_wdata;
        REG_ATTACK:    cfg_r.attack_coeff  <= cfg_wdata;
        REG_RELEASE:   cfg_r.release_coeff <= cfg_wdata;
        default: ;
      endcase
    end
  end

  fac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .enable    (cfg_r.enable),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  fac_dp #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cmd        (cmd),
    .sample_in  (in_chan.sample_in),
    .sample_out (out_chan.sample_out)
  );

endmodule
`default_nettype wire
